FILE: sv/leb_pkg.sv
// Shared types and constants of the line edit buffer.
// Used by leb_shift_unit and line_edit_buffer_core; depends on nothing.
package leb_pkg;

    // Field widths
    localparam int DATA_W        = 8;
    localparam int POS_W         = 8;
    localparam int CMD_W         = 4;
    localparam int RIDX_W        = 7;

    // Defaults
    localparam int          DEFAULT_DEPTH = 128;
    localparam logic [7:0]  CAP_RESET     = 8'd128;

    // Edit commands
    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR      = 4'd0,
        CMD_INSERT     = 4'd1,
        CMD_BACKSPACE  = 4'd2,
        CMD_DELETE     = 4'd3,
        CMD_LEFT       = 4'd4,
        CMD_RIGHT      = 4'd5,
        CMD_HOME       = 4'd6,
        CMD_END        = 4'd7,
        CMD_KILL_START = 4'd8,
        CMD_KILL_END   = 4'd9,
        CMD_READ       = 4'd10
    } t_cmd;

    // Sequencer states of the core
    typedef enum logic [1:0] {
        S_IDLE,
        S_SHIFT,
        S_FINISH
    } t_state;

    // Request to move a run of bytes inside the line store
    typedef struct packed {
        logic             start;
        logic             up;
        logic [POS_W-1:0] src;
        logic [POS_W-1:0] dst;
        logic [POS_W-1:0] count;
    } t_move_req;

    // Direct single-byte access to the line store
    typedef struct packed {
        logic              wr_en;
        logic [POS_W-1:0]  wr_pos;
        logic [DATA_W-1:0] wr_data;
        logic              rd_en;
        logic [POS_W-1:0]  rd_pos;
    } t_port_req;

endpackage

FILE: sv/line_edit_buffer_core.sv
// Top level of the line edit buffer: command decode, sequencer and result register.
// Depends on leb_pkg and leb_shift_unit.
//
// One text line of up to LINE_DEPTH-1 bytes is kept with its length and cursor; each
// input transfer applies one edit command and yields one result transfer with ok,
// length, cursor and the byte read. Commands that move text (insert, backspace,
// delete, kill to start) shift the tail through the line store one byte per cycle;
// the number of bytes shifted is length - cursor, one fewer for delete. A command with
// nothing to shift, and every other command, goes from idle straight to the finish
// state, and a finished result waits there while the result channel stalls. Input stall
// stays high for the whole command; a finished result waits in the output register
// while the next command is taken. Capacity must be written only while the block is
// idle; the block itself does not enforce this.
module line_edit_buffer_core #(
    parameter int LINE_DEPTH = leb_pkg::DEFAULT_DEPTH
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // configuration
    input  logic                       i_cfg_we,
    input  logic [7:0]                 i_cfg_wdata,
    // command channel
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic [leb_pkg::CMD_W-1:0]  i_command,
    input  logic [leb_pkg::DATA_W-1:0] i_char_in,
    input  logic [leb_pkg::RIDX_W-1:0] i_read_index,
    // result channel
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic                       o_ok,
    output logic [leb_pkg::POS_W-1:0]  o_line_length,
    output logic [leb_pkg::POS_W-1:0]  o_cursor_pos,
    output logic [leb_pkg::DATA_W-1:0] o_char_out
);
    import leb_pkg::*;

    localparam logic [7:0] CAP_MAX = 8'((LINE_DEPTH < 255) ? LINE_DEPTH : 255);

    t_state            r_state, n_state;
    logic [7:0]        r_cap;
    logic [POS_W-1:0]  r_length, r_cursor;

    logic              r_ok, r_settle, r_ins, r_is_read;
    logic [POS_W-1:0]  r_new_len, r_new_cur, r_ins_pos;
    logic [DATA_W-1:0] r_char;

    logic              r_out_valid, r_out_ok;
    logic [POS_W-1:0]  r_out_len, r_out_cur;
    logic [DATA_W-1:0] r_out_char;

    logic [7:0]        cap_eff;
    logic              in_xfer, fin_done;
    logic              dec_ok, dec_settle;
    logic [POS_W-1:0]  dec_len, dec_cur;
    logic [POS_W-1:0]  fin_len, fin_cur;
    t_move_req         move;
    t_port_req         port;
    logic              busy;
    logic [DATA_W-1:0] rdata;

    assign cap_eff = (r_cap > CAP_MAX) ? CAP_MAX : r_cap;
    assign in_xfer = (r_state == S_IDLE) && i_in_valid;

    // Decode the command against the current line
    always_comb begin
        dec_ok     = 1'b0;
        dec_len    = r_length;
        dec_cur    = r_cursor;
        move.start = 1'b0;
        move.up    = 1'b1;
        move.src   = r_cursor;
        move.dst   = r_cursor;
        move.count = '0;
        case (t_cmd'(i_command))
            CMD_CLEAR: begin
                if (cap_eff != '0) begin
                    dec_ok  = 1'b1;
                    dec_len = '0;
                    dec_cur = '0;
                end
            end
            CMD_INSERT: begin
                if (cap_eff != '0 && r_length < cap_eff - 8'd1) begin
                    dec_ok     = 1'b1;
                    dec_len    = r_length + POS_W'(1);
                    dec_cur    = r_cursor + POS_W'(1);
                    move.up    = 1'b0;
                    move.src   = r_length - POS_W'(1);
                    move.dst   = r_length;
                    move.count = r_length - r_cursor;
                end
            end
            CMD_BACKSPACE: begin
                if (cap_eff != '0 && r_cursor != '0 && r_length != '0) begin
                    dec_ok     = 1'b1;
                    dec_len    = r_length - POS_W'(1);
                    dec_cur    = r_cursor - POS_W'(1);
                    move.src   = r_cursor;
                    move.dst   = r_cursor - POS_W'(1);
                    move.count = r_length - r_cursor;
                end
            end
            CMD_DELETE: begin
                if (cap_eff != '0 && r_cursor < r_length) begin
                    dec_ok     = 1'b1;
                    dec_len    = r_length - POS_W'(1);
                    move.src   = r_cursor + POS_W'(1);
                    move.dst   = r_cursor;
                    move.count = r_length - r_cursor - POS_W'(1);
                end
            end
            CMD_LEFT: begin
                if (r_cursor != '0) begin
                    dec_ok  = 1'b1;
                    dec_cur = r_cursor - POS_W'(1);
                end
            end
            CMD_RIGHT: begin
                if (r_cursor < r_length) begin
                    dec_ok  = 1'b1;
                    dec_cur = r_cursor + POS_W'(1);
                end
            end
            CMD_HOME: begin
                dec_ok  = 1'b1;
                dec_cur = '0;
            end
            CMD_END: begin
                dec_ok  = 1'b1;
                dec_cur = r_length;
            end
            CMD_KILL_START: begin
                if (r_cursor != '0) begin
                    dec_ok     = 1'b1;
                    dec_len    = r_length - r_cursor;
                    dec_cur    = '0;
                    move.src   = r_cursor;
                    move.dst   = '0;
                    move.count = r_length - r_cursor;
                end
            end
            CMD_KILL_END: begin
                if (r_cursor < r_length) begin
                    dec_ok  = 1'b1;
                    dec_len = r_cursor;
                end
            end
            CMD_READ: begin
                dec_ok = (POS_W'(i_read_index) < r_length);
            end
            default: begin
                dec_ok = 1'b0;
            end
        endcase
        dec_settle = dec_ok && (i_command inside {CMD_INSERT, CMD_BACKSPACE, CMD_DELETE,
                                                  CMD_KILL_START, CMD_KILL_END});
        move.start = in_xfer && dec_ok && (move.count != '0);
    end

    // Trim length and cursor to the capacity after an edit
    always_comb begin
        fin_len = r_new_len;
        fin_cur = r_new_cur;
        if (r_settle && cap_eff != '0) begin
            if (r_new_len >= cap_eff) begin
                fin_len = cap_eff - 8'd1;
            end
            if (r_new_cur > fin_len) begin
                fin_cur = fin_len;
            end
        end
    end

    // Next state and store access
    always_comb begin
        n_state      = r_state;
        fin_done     = 1'b0;
        port.wr_en   = 1'b0;
        port.wr_pos  = r_ins_pos;
        port.wr_data = r_char;
        port.rd_en   = 1'b0;
        port.rd_pos  = POS_W'(i_read_index);
        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    port.rd_en = (t_cmd'(i_command) == CMD_READ) && dec_ok;
                    n_state    = move.start ? S_SHIFT : S_FINISH;
                end
            end
            S_SHIFT: begin
                if (!busy) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (!r_out_valid || !i_out_stall) begin
                    fin_done   = 1'b1;
                    port.wr_en = r_ins;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Capacity, line length and cursor
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap    <= CAP_RESET;
            r_length <= '0;
            r_cursor <= '0;
        end else begin
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
            if (fin_done) begin
                r_length <= fin_len;
                r_cursor <= fin_cur;
            end
        end
    end

    // Hold the decoded command while it runs
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_ok      <= dec_ok;
            r_settle  <= dec_settle;
            r_ins     <= dec_ok && (t_cmd'(i_command) == CMD_INSERT);
            r_is_read <= (t_cmd'(i_command) == CMD_READ);
            r_new_len <= dec_len;
            r_new_cur <= dec_cur;
            r_ins_pos <= r_cursor;
            r_char    <= i_char_in;
        end
    end

    // Result register: load when free or taken, drop on transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fin_done) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fin_done) begin
            r_out_ok   <= r_ok;
            r_out_len  <= fin_len;
            r_out_cur  <= fin_cur;
            r_out_char <= (r_is_read && r_ok) ? rdata : '0;
        end
    end

    leb_shift_unit #(
        .LINE_DEPTH (LINE_DEPTH)
    ) u_shift (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_move  (move),
        .i_port  (port),
        .o_busy  (busy),
        .o_rdata (rdata)
    );

    assign o_in_stall    = (r_state != S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_ok          = r_out_ok;
    assign o_line_length = r_out_len;
    assign o_cursor_pos  = r_out_cur;
    assign o_char_out    = r_out_char;

    // Cursor never passes the end of the line
    a_cursor_in_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cursor <= r_length)
        else $error("cursor beyond line length");

    // Line always fits in the store
    a_length_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_length < LINE_DEPTH)
        else $error("line length exceeds store depth");

    // A taken command leaves idle at once
    a_busy_after_xfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> r_state != S_IDLE)
        else $error("command accepted without leaving idle");

endmodule

FILE: sv/leb_shift_unit.sv
// Line store memory with a one-byte-per-cycle move engine.
// Depends on leb_pkg for the request structs and widths.
module leb_shift_unit #(
    parameter int LINE_DEPTH = leb_pkg::DEFAULT_DEPTH
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  leb_pkg::t_move_req         i_move,
    input  leb_pkg::t_port_req         i_port,
    output logic                       o_busy,
    output logic [leb_pkg::DATA_W-1:0] o_rdata
);
    import leb_pkg::*;

    localparam int AW = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;

    logic [DATA_W-1:0] mem [LINE_DEPTH];
    logic [DATA_W-1:0] r_rdata;

    logic [POS_W-1:0]  r_src, n_src;
    logic [POS_W-1:0]  r_dst, n_dst;
    logic [POS_W-1:0]  r_cnt, n_cnt;
    logic              r_up;
    logic              r_pend;
    logic [POS_W-1:0]  r_pend_dst;

    logic              mem_we, mem_re;
    logic [AW-1:0]     wr_addr, rd_addr;
    logic [DATA_W-1:0] wr_data;

    // Step source and destination together, one byte per cycle
    always_comb begin
        n_src = r_up ? r_src + POS_W'(1) : r_src - POS_W'(1);
        n_dst = r_up ? r_dst + POS_W'(1) : r_dst - POS_W'(1);
        n_cnt = r_cnt - POS_W'(1);
    end

    // Move sequencer: read at source, write the byte back in the following cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_pend <= 1'b0;
        end else begin
            r_pend <= (r_cnt != '0);
            if (i_move.start) begin
                r_cnt <= i_move.count;
            end else if (r_cnt != '0) begin
                r_cnt <= n_cnt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_move.start) begin
            r_src <= i_move.src;
            r_dst <= i_move.dst;
            r_up  <= i_move.up;
        end else if (r_cnt != '0) begin
            r_src <= n_src;
            r_dst <= n_dst;
        end
        r_pend_dst <= r_dst;
    end

    // Select memory port: move engine or direct access
    always_comb begin
        mem_re  = (r_cnt != '0) || i_port.rd_en;
        rd_addr = (r_cnt != '0) ? AW'(r_src) : AW'(i_port.rd_pos);
        mem_we  = r_pend || i_port.wr_en;
        wr_addr = r_pend ? AW'(r_pend_dst) : AW'(i_port.wr_pos);
        wr_data = r_pend ? r_rdata : i_port.wr_data;
    end

    // Line store with registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[wr_addr] <= wr_data;
        end
        if (mem_re) begin
            r_rdata <= mem[rd_addr];
        end
    end

    assign o_busy  = (r_cnt != '0) || r_pend;
    assign o_rdata = r_rdata;

    // A pending write always follows a read issued in the cycle before
    a_pend_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> $past(r_cnt) != '0)
        else $error("write-back without a preceding read");

    // No new move while one is in flight
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_move.start |-> !o_busy)
        else $error("move started while busy");

    // Count drops by one per cycle while moving
    a_cnt_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt != '0 && !i_move.start) |=> r_cnt == POS_W'($past(r_cnt) - POS_W'(1)))
        else $error("move count skipped");

    // Read and write in one cycle never hit the same byte
    a_no_collide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mem_we && mem_re) |-> wr_addr != rd_addr)
        else $error("read and write at the same address");

endmodule
